/* rtl/lbc_pkg.sv */
// Shared types and constants for the fourth-order low-pass biquad cascade.
// Used by lbc_ctrl, lbc_datapath and the top level; no dependencies.
package lbc_pkg;

    // Field and format widths
    localparam int SAMPLE_W         = 16;
    localparam int COEF_W           = 44;
    localparam int SIG_W            = 40;
    localparam int COEF_FRAC_BITS   = 40;
    localparam int SIGNAL_FRAC_BITS = 16;
    localparam int XS_W             = SIG_W + 2;       // feed-forward sum x0 + 2*x1 + x2
    localparam int FF_W             = SAMPLE_W + 2;    // raw-sample feed-forward sum
    localparam int ACC_W            = COEF_W + XS_W + 2;
    localparam int SHR_W            = ACC_W - COEF_FRAC_BITS;
    localparam int INT_W            = SIG_W + 1 - SIGNAL_FRAC_BITS;

    // Split of each coefficient product into four partial products
    localparam int C_LO_W = COEF_W / 2;
    localparam int D_LO_W = XS_W / 2;
    localparam int CP_W   = COEF_W - C_LO_W + 1;
    localparam int DP_W   = XS_W - D_LO_W + 1;
    localparam int PP_W   = CP_W + DP_W;

    // Sequencing: three products per section, four partial products each
    localparam int STEP_W        = 4;
    localparam int STEPS_PER_SEC = 12;

    // Configuration register indexes
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] REG_FIRST_A1    = 3'd0;
    localparam logic [IDX_W-1:0] REG_FIRST_A2    = 3'd1;
    localparam logic [IDX_W-1:0] REG_FIRST_GAIN  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SECOND_A1   = 3'd3;
    localparam logic [IDX_W-1:0] REG_SECOND_A2   = 3'd4;
    localparam logic [IDX_W-1:0] REG_SECOND_GAIN = 3'd5;

    // Coefficient reset values, Q3.40
    localparam logic signed [COEF_W-1:0] FIRST_A1_RST    = -44'sd2191023329552;
    localparam logic signed [COEF_W-1:0] FIRST_A2_RST    = 44'sd1091609015776;
    localparam logic signed [COEF_W-1:0] FIRST_GAIN_RST  = 44'sd24328500;
    localparam logic signed [COEF_W-1:0] SECOND_A1_RST   = -44'sd2179944305552;
    localparam logic signed [COEF_W-1:0] SECOND_A2_RST   = 44'sd1080529507776;
    localparam logic signed [COEF_W-1:0] SECOND_GAIN_RST = 44'sd24205480;

    // Saturation bounds
    localparam logic signed [SIG_W-1:0]    SIG_MAX    = {1'b0, {(SIG_W-1){1'b1}}};
    localparam logic signed [SIG_W-1:0]    SIG_MIN    = {1'b1, {(SIG_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              load_in;   // capture sample, form first-section sum
        logic              mul_en;    // issue one partial product
        logic              round;     // round and saturate the accumulator
        logic              load_xs2;  // form second-section sum
        logic              commit;    // update histories, load output
        logic              sec;       // 0: first section, 1: second section
        logic [STEP_W-1:0] step;      // term in [3:2], partial product in [1:0]
    } lbc_cmd_t;

endpackage

/* rtl/lbc_ctrl.sv */
// Controller for the biquad cascade: sequences the shared multiplier,
// rounding and history commit, and owns both handshakes. Uses lbc_pkg.
module lbc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output lbc_pkg::lbc_cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_XS2   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                  state_reg, state_next;
    logic [lbc_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        sec_reg, sec_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        sec_next     = sec_reg;
        cmd          = '0;
        cmd.sec      = sec_reg;
        cmd.step     = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    sec_next    = 1'b0;
                    step_next   = '0;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                if (step_reg == lbc_pkg::STEP_W'(lbc_pkg::STEPS_PER_SEC - 1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                // last partial product lands in the accumulator here
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = sec_reg ? S_DONE : S_XS2;
            end
            S_XS2:
            begin
                cmd.load_xs2 = 1'b1;
                sec_next     = 1'b1;
                step_next    = '0;
                state_next   = S_MUL;
            end
            S_DONE:
            begin
                // hold until the output register can take the result
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            sec_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sec_reg       <= sec_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/lbc_datapath.sv */
// Datapath for the biquad cascade: coefficient registers, histories, the
// shared 23x22 multiplier, the wide accumulator and rounding. Uses lbc_pkg.
module lbc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lbc_pkg::lbc_cmd_t                   cmd,
    input  logic signed [lbc_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                                cfg_wr_en,
    input  logic [lbc_pkg::IDX_W-1:0]           cfg_index,
    input  logic [lbc_pkg::COEF_W-1:0]          cfg_data,
    output logic signed [lbc_pkg::SAMPLE_W-1:0] sample_out
);

    // Coefficients
    logic signed [lbc_pkg::COEF_W-1:0] first_a1_reg, first_a2_reg, first_gain_reg;
    logic signed [lbc_pkg::COEF_W-1:0] second_a1_reg, second_a2_reg, second_gain_reg;

    // Histories (entry 0 newest)
    logic signed [lbc_pkg::SAMPLE_W-1:0] in_hist0_reg, in_hist1_reg;
    logic signed [lbc_pkg::SIG_W-1:0]    out1_hist0_reg, out1_hist1_reg;
    logic signed [lbc_pkg::SIG_W-1:0]    out2_hist0_reg, out2_hist1_reg;

    // Working registers
    logic signed [lbc_pkg::SAMPLE_W-1:0] sample_reg;
    logic signed [lbc_pkg::XS_W-1:0]     xs_reg;
    logic signed [lbc_pkg::SIG_W-1:0]    y1_reg, y2_reg;
    logic signed [lbc_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic signed [lbc_pkg::PP_W-1:0]     pp_reg;
    logic                                pp_valid_reg;
    logic                                pp_sub_reg;
    logic [1:0]                          pp_part_reg;
    logic signed [lbc_pkg::SAMPLE_W-1:0] out_data_reg;

    logic signed [lbc_pkg::ACC_W-1:0]    acc_half;
    logic signed [lbc_pkg::FF_W-1:0]     ff_sum;
    logic signed [lbc_pkg::XS_W-1:0]     xs1, xs2;
    logic signed [lbc_pkg::COEF_W-1:0]   coef_sel;
    logic signed [lbc_pkg::XS_W-1:0]     opnd_sel;
    logic                                sub_sel;
    logic signed [lbc_pkg::CP_W-1:0]     coef_part;
    logic signed [lbc_pkg::DP_W-1:0]     opnd_part;
    logic signed [lbc_pkg::PP_W-1:0]     pp_next;
    logic signed [lbc_pkg::ACC_W-1:0]    pp_ext, addend;
    logic signed [lbc_pkg::SHR_W-1:0]    acc_shr;
    logic signed [lbc_pkg::SIG_W-1:0]    y_sat;
    logic signed [lbc_pkg::SIG_W:0]      y2_rnd;
    logic signed [lbc_pkg::INT_W-1:0]    y2_int;
    logic signed [lbc_pkg::SAMPLE_W-1:0] out_sat;

    assign acc_half = lbc_pkg::ACC_W'(1) <<< (lbc_pkg::COEF_FRAC_BITS - 1);

    // Feed-forward sums
    assign ff_sum = lbc_pkg::FF_W'(sample_in)
                  + (lbc_pkg::FF_W'(in_hist0_reg) <<< 1)
                  + lbc_pkg::FF_W'(in_hist1_reg);
    assign xs1 = lbc_pkg::XS_W'(ff_sum) <<< lbc_pkg::SIGNAL_FRAC_BITS;
    assign xs2 = lbc_pkg::XS_W'(y1_reg)
               + (lbc_pkg::XS_W'(out1_hist0_reg) <<< 1)
               + lbc_pkg::XS_W'(out1_hist1_reg);

    // Operand select: term 0 is gain*xs, terms 1 and 2 subtract the feedback
    always_comb
    begin
        case (cmd.step[3:2])
            2'd0:
            begin
                coef_sel = cmd.sec ? second_gain_reg : first_gain_reg;
                opnd_sel = xs_reg;
                sub_sel  = 1'b0;
            end
            2'd1:
            begin
                coef_sel = cmd.sec ? second_a1_reg : first_a1_reg;
                opnd_sel = cmd.sec ? lbc_pkg::XS_W'(out2_hist0_reg)
                                   : lbc_pkg::XS_W'(out1_hist0_reg);
                sub_sel  = 1'b1;
            end
            2'd2:
            begin
                coef_sel = cmd.sec ? second_a2_reg : first_a2_reg;
                opnd_sel = cmd.sec ? lbc_pkg::XS_W'(out2_hist1_reg)
                                   : lbc_pkg::XS_W'(out1_hist1_reg);
                sub_sel  = 1'b1;
            end
            default:
            begin
                coef_sel = '0;
                opnd_sel = '0;
                sub_sel  = 1'b0;
            end
        endcase
    end

    // Low halves are unsigned, high halves carry the sign
    assign coef_part = cmd.step[0]
        ? {coef_sel[lbc_pkg::COEF_W-1], coef_sel[lbc_pkg::COEF_W-1:lbc_pkg::C_LO_W]}
        : {{(lbc_pkg::CP_W - lbc_pkg::C_LO_W){1'b0}}, coef_sel[lbc_pkg::C_LO_W-1:0]};
    assign opnd_part = cmd.step[1]
        ? {opnd_sel[lbc_pkg::XS_W-1], opnd_sel[lbc_pkg::XS_W-1:lbc_pkg::D_LO_W]}
        : {{(lbc_pkg::DP_W - lbc_pkg::D_LO_W){1'b0}}, opnd_sel[lbc_pkg::D_LO_W-1:0]};
    assign pp_next = coef_part * opnd_part;

    // Align the registered partial product
    assign pp_ext = lbc_pkg::ACC_W'(pp_reg);
    always_comb
    begin
        case (pp_part_reg)
            2'd0:    addend = pp_ext;
            2'd1:    addend = pp_ext <<< lbc_pkg::C_LO_W;
            2'd2:    addend = pp_ext <<< lbc_pkg::D_LO_W;
            default: addend = pp_ext <<< (lbc_pkg::C_LO_W + lbc_pkg::D_LO_W);
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.load_in || cmd.load_xs2)
        begin
            acc_next = acc_half;
        end
        else if (pp_valid_reg)
        begin
            acc_next = pp_sub_reg ? (acc_reg - addend) : (acc_reg + addend);
        end
    end

    // Section result: drop fraction bits, saturate to the signal range
    assign acc_shr = acc_reg[lbc_pkg::ACC_W-1:lbc_pkg::COEF_FRAC_BITS];
    always_comb
    begin
        if (acc_shr > lbc_pkg::SHR_W'(lbc_pkg::SIG_MAX))
        begin
            y_sat = lbc_pkg::SIG_MAX;
        end
        else if (acc_shr < lbc_pkg::SHR_W'(lbc_pkg::SIG_MIN))
        begin
            y_sat = lbc_pkg::SIG_MIN;
        end
        else
        begin
            y_sat = acc_shr[lbc_pkg::SIG_W-1:0];
        end
    end

    // Output: round half up to an integer, saturate to 16 bits
    assign y2_rnd = (lbc_pkg::SIG_W + 1)'(y2_reg)
                  + ((lbc_pkg::SIG_W + 1)'(1) <<< (lbc_pkg::SIGNAL_FRAC_BITS - 1));
    assign y2_int = y2_rnd[lbc_pkg::SIG_W:lbc_pkg::SIGNAL_FRAC_BITS];
    always_comb
    begin
        if (y2_int > lbc_pkg::INT_W'(lbc_pkg::SAMPLE_MAX))
        begin
            out_sat = lbc_pkg::SAMPLE_MAX;
        end
        else if (y2_int < lbc_pkg::INT_W'(lbc_pkg::SAMPLE_MIN))
        begin
            out_sat = lbc_pkg::SAMPLE_MIN;
        end
        else
        begin
            out_sat = y2_int[lbc_pkg::SAMPLE_W-1:0];
        end
    end

    assign sample_out = out_data_reg;

    // Control state, coefficients and histories
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_valid_reg    <= 1'b0;
            first_a1_reg    <= lbc_pkg::FIRST_A1_RST;
            first_a2_reg    <= lbc_pkg::FIRST_A2_RST;
            first_gain_reg  <= lbc_pkg::FIRST_GAIN_RST;
            second_a1_reg   <= lbc_pkg::SECOND_A1_RST;
            second_a2_reg   <= lbc_pkg::SECOND_A2_RST;
            second_gain_reg <= lbc_pkg::SECOND_GAIN_RST;
            in_hist0_reg    <= '0;
            in_hist1_reg    <= '0;
            out1_hist0_reg  <= '0;
            out1_hist1_reg  <= '0;
            out2_hist0_reg  <= '0;
            out2_hist1_reg  <= '0;
        end
        else
        begin
            pp_valid_reg <= cmd.mul_en;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    lbc_pkg::REG_FIRST_A1:    first_a1_reg    <= cfg_data;
                    lbc_pkg::REG_FIRST_A2:    first_a2_reg    <= cfg_data;
                    lbc_pkg::REG_FIRST_GAIN:  first_gain_reg  <= cfg_data;
                    lbc_pkg::REG_SECOND_A1:   second_a1_reg   <= cfg_data;
                    lbc_pkg::REG_SECOND_A2:   second_a2_reg   <= cfg_data;
                    lbc_pkg::REG_SECOND_GAIN: second_gain_reg <= cfg_data;
                    default:
                    begin
                        // drop writes to unknown indexes
                    end
                endcase
            end
            if (cmd.commit)
            begin
                in_hist1_reg   <= in_hist0_reg;
                in_hist0_reg   <= sample_reg;
                out1_hist1_reg <= out1_hist0_reg;
                out1_hist0_reg <= y1_reg;
                out2_hist1_reg <= out2_hist0_reg;
                out2_hist0_reg <= y2_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd.load_in)
        begin
            sample_reg <= sample_in;
            xs_reg     <= xs1;
        end
        else if (cmd.load_xs2)
        begin
            xs_reg <= xs2;
        end
        if (cmd.mul_en)
        begin
            pp_reg      <= pp_next;
            pp_sub_reg  <= sub_sel;
            pp_part_reg <= cmd.step[1:0];
        end
        if (cmd.round)
        begin
            if (cmd.sec)
            begin
                y2_reg <= y_sat;
            end
            else
            begin
                y1_reg <= y_sat;
            end
        end
        if (cmd.commit)
        begin
            out_data_reg <= out_sat;
        end
    end

endmodule

/* rtl/lowpass_biquad_cascade_4th_order.sv */
// Fourth-order low-pass filter: two cascaded biquad sections, Q3.40 coefficients.
// Samples are taken one at a time: in_stall is high from the input transfer until
//   the result commits, paced by the single shared 23x22 multiplier,
//   which takes four partial products per coefficient product, 12 per section.
// Reset: coefficients load their default Butterworth values, all histories clear,
//   no output is pending. Depends on lbc_pkg, lbc_ctrl and lbc_datapath.
module lowpass_biquad_cascade_4th_order (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [lbc_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [lbc_pkg::SAMPLE_W-1:0] sample_out,
    input  logic                                cfg_wr_en,
    input  logic [lbc_pkg::IDX_W-1:0]           cfg_index,
    input  logic [lbc_pkg::COEF_W-1:0]          cfg_data
);

    lbc_pkg::lbc_cmd_t cmd;

    lbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    lbc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sample_in  (sample_in),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_out (sample_out)
    );

endmodule
